>>> rtl/core/bounded_deque_engine_unit_defines.svh
// Assertion macros shared by the checker of bounded_deque_engine_unit.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef BOUNDED_DEQUE_ENGINE_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define BDE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bde_pkg.sv
// Shared constants, codes and the cell control struct of the deque engine.
// No dependencies.
`default_nettype none
package bde_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CELL_W     = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // request kinds
    localparam logic [3:0] K_PUSH_BACK  = 4'd0;
    localparam logic [3:0] K_PUSH_FRONT = 4'd1;
    localparam logic [3:0] K_POP_BACK   = 4'd2;
    localparam logic [3:0] K_POP_FRONT  = 4'd3;
    localparam logic [3:0] K_PEEK_BACK  = 4'd4;
    localparam logic [3:0] K_PEEK_FRONT = 4'd5;
    localparam logic [3:0] K_READ_AT    = 4'd6;
    localparam logic [3:0] K_REMOVE_AT  = 4'd7;
    localparam logic [3:0] K_REMOVE_VAL = 4'd8;

    // result status
    localparam logic [1:0] S_OK       = 2'd0;
    localparam logic [1:0] S_EMPTY    = 2'd1;
    localparam logic [1:0] S_FULL     = 2'd2;
    localparam logic [1:0] S_NOTFOUND = 2'd3;

    // cell operations
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_SHR  = 2'd1;  // take left neighbor
    localparam logic [1:0] OP_LOAD = 2'd2;  // write value at target
    localparam logic [1:0] OP_SHL  = 2'd3;  // target and above take right neighbor

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  target;
        logic [CELL_W-1:0] value;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> rtl/core/bde_cell.sv
// One storage cell of the deque chain; holds the entry at its logical index.
// Depends on bde_pkg.
`default_nettype none
module bde_cell (
    input  wire logic                      i_clk,
    input  wire bde_pkg::t_cell_ctl        i_ctl,
    input  wire logic [bde_pkg::IDX_W-1:0] i_index,
    input  wire logic [bde_pkg::CELL_W-1:0] i_left,
    input  wire logic [bde_pkg::CELL_W-1:0] i_right,
    output logic      [bde_pkg::CELL_W-1:0] o_data
);

    logic [bde_pkg::CELL_W-1:0] r_data;
    logic [bde_pkg::CELL_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            bde_pkg::OP_HOLD: n_data = r_data;
            bde_pkg::OP_SHR:  n_data = i_left;
            bde_pkg::OP_LOAD: begin
                if (i_index == i_ctl.target) n_data = i_ctl.value;
            end
            bde_pkg::OP_SHL: begin
                if (i_index >= i_ctl.target) n_data = i_right;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

>>> rtl/core/bounded_deque_engine_unit.sv
// Top level of the bounded deque engine: request sequencer and chain of cells.
// Depends on bde_pkg and bde_cell.
//
//  channel  | handshake              | words
//  ---------+------------------------+------------------------------------
//  request  | i_start, o_busy        | i_kind, i_value, i_position
//  result   | o_valid (1-cycle pulse) | o_data_out, o_status, o_count
//
// A word is taken when i_start is high and o_busy low; the sequencer then enters ST_EXEC,
// and for every kind but remove by value the result pulses in the cycle after ST_EXEC.
// Remove by value then scans one cell per cycle in ST_SCAN from index 0; it ends on a match
// or when the scan counter reaches the count, and then pulses the result.
// i_rst_n (synchronous) empties the deque; cell contents are not cleared.
// The result cannot be stalled; a new word may be taken while it is shown.
`default_nettype none
module bounded_deque_engine_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [3:0]  i_kind,
    input  wire logic [31:0] i_value,
    input  wire logic [3:0]  i_position,
    output logic             o_valid,
    output logic      [31:0] o_data_out,
    output logic      [1:0]  o_status,
    output logic      [4:0]  o_count
);

    localparam int CMP_W = (bde_pkg::CNT_W > 4) ? bde_pkg::CNT_W : 4;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [3:0]                  r_kind;
    logic [bde_pkg::CELL_W-1:0]  r_value;
    logic [3:0]                  r_pos;
    logic [bde_pkg::CNT_W-1:0]   r_count, n_count;
    logic [bde_pkg::CNT_W-1:0]   r_scan, n_scan;
    logic                        r_strobe, n_strobe;
    logic [bde_pkg::CELL_W-1:0]  r_data, n_data;
    logic [1:0]                  r_status, n_status;

    bde_pkg::t_cell_ctl          w_ctl;
    logic [bde_pkg::IDX_W-1:0]   w_rd_idx;
    logic [bde_pkg::CELL_W-1:0]  w_rd_data;
    logic [bde_pkg::CELL_W-1:0]  w_cell [bde_pkg::DEPTH];
    logic                        w_accept;
    logic                        w_full;
    logic                        w_empty;
    logic                        w_pos_bad;

    assign w_accept  = i_start && !o_busy;
    assign w_full    = (r_count == bde_pkg::CNT_W'(bde_pkg::DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_pos_bad = (CMP_W'(r_pos) >= CMP_W'(r_count));

    // single read tap on the chain
    always_comb begin
        w_rd_idx = '0;
        case (r_kind)
            bde_pkg::K_POP_BACK, bde_pkg::K_PEEK_BACK:
                w_rd_idx = bde_pkg::IDX_W'(r_count - 1'b1);
            bde_pkg::K_READ_AT, bde_pkg::K_REMOVE_AT:
                w_rd_idx = bde_pkg::IDX_W'(r_pos);
            bde_pkg::K_REMOVE_VAL:
                w_rd_idx = r_scan[bde_pkg::IDX_W-1:0];
            default: w_rd_idx = '0;
        endcase
    end

    assign w_rd_data = w_cell[w_rd_idx];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_scan       = r_scan;
        n_strobe     = 1'b0;
        n_data       = '0;
        n_status     = bde_pkg::S_OK;
        w_ctl.op     = bde_pkg::OP_HOLD;
        w_ctl.target = '0;
        w_ctl.value  = r_value;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state  = ST_IDLE;
                n_strobe = 1'b1;
                case (r_kind)
                    bde_pkg::K_PUSH_BACK, bde_pkg::K_PUSH_FRONT: begin
                        if (w_full) begin
                            n_status = bde_pkg::S_FULL;
                        end else begin
                            n_count = r_count + 1'b1;
                            if (r_kind == bde_pkg::K_PUSH_BACK) begin
                                w_ctl.op     = bde_pkg::OP_LOAD;
                                w_ctl.target = r_count[bde_pkg::IDX_W-1:0];
                            end else begin
                                w_ctl.op = bde_pkg::OP_SHR;
                            end
                        end
                    end
                    bde_pkg::K_POP_BACK, bde_pkg::K_PEEK_BACK,
                    bde_pkg::K_POP_FRONT, bde_pkg::K_PEEK_FRONT: begin
                        if (w_empty) begin
                            n_status = bde_pkg::S_EMPTY;
                        end else begin
                            n_data = w_rd_data;
                            if (r_kind == bde_pkg::K_POP_BACK) n_count = r_count - 1'b1;
                            if (r_kind == bde_pkg::K_POP_FRONT) begin
                                n_count  = r_count - 1'b1;
                                w_ctl.op = bde_pkg::OP_SHL;
                            end
                        end
                    end
                    bde_pkg::K_READ_AT, bde_pkg::K_REMOVE_AT: begin
                        if (w_pos_bad) begin
                            n_status = bde_pkg::S_EMPTY;
                        end else begin
                            n_data = w_rd_data;
                            if (r_kind == bde_pkg::K_REMOVE_AT) begin
                                n_count      = r_count - 1'b1;
                                w_ctl.op     = bde_pkg::OP_SHL;
                                w_ctl.target = bde_pkg::IDX_W'(r_pos);
                            end
                        end
                    end
                    bde_pkg::K_REMOVE_VAL: begin
                        n_strobe = 1'b0;
                        n_scan   = '0;
                        n_state  = ST_SCAN;
                    end
                    default: n_status = bde_pkg::S_OK;
                endcase
            end
            ST_SCAN: begin
                if (r_scan >= r_count) begin
                    n_state  = ST_IDLE;
                    n_strobe = 1'b1;
                    n_status = bde_pkg::S_NOTFOUND;
                end else if (w_rd_data == r_value) begin
                    n_state      = ST_IDLE;
                    n_strobe     = 1'b1;
                    n_data       = w_rd_data;
                    n_count      = r_count - 1'b1;
                    w_ctl.op     = bde_pkg::OP_SHL;
                    w_ctl.target = r_scan[bde_pkg::IDX_W-1:0];
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_scan   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_scan   <= n_scan;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_value <= i_value[bde_pkg::CELL_W-1:0];
            r_pos   <= i_position;
        end
        if (n_strobe) begin
            r_data   <= n_data;
            r_status <= n_status;
        end
    end

    for (genvar g = 0; g < bde_pkg::DEPTH; g++) begin : g_cell
        logic [bde_pkg::CELL_W-1:0] w_left;
        logic [bde_pkg::CELL_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_ctl.value;
        end else begin : g_mid
            assign w_left = w_cell[g-1];
        end
        if (g == bde_pkg::DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_cell[g+1];
        end
        bde_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (bde_pkg::IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell[g])
        );
    end

    assign o_busy     = (r_state != ST_IDLE);
    assign o_valid    = r_strobe;
    assign o_data_out = 32'(r_data);
    assign o_status   = r_status;
    assign o_count    = 5'(r_count);

endmodule
`default_nettype wire

>>> rtl/core/bde_checker.sv
// Port-level checker for bounded_deque_engine_unit, attached by bind.
// Depends on bde_pkg and bounded_deque_engine_unit_defines.svh.
`default_nettype none
`include "bounded_deque_engine_unit_defines.svh"
module bde_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       o_busy,
    input wire logic       o_valid,
    input wire logic [1:0] o_status,
    input wire logic [4:0] o_count
);

    `BDE_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy, "accepted word did not raise busy")
    `BDE_ASSERT_NEXT(a_accept_no_result, i_start && !o_busy, !o_valid, "result one cycle after accept")
    `BDE_ASSERT_NOW(a_single_pulse, o_valid, !$past(o_valid), "result strobe longer than one cycle")
    `BDE_ASSERT_NOW(a_fail_keeps_count, o_valid && o_status != bde_pkg::S_OK,
        o_count == $past(o_count), "failed request changed the count")

endmodule

bind bounded_deque_engine_unit bde_checker u_bde_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_status (o_status),
    .o_count  (o_count)
);
`default_nettype wire
